FILE: rtl/oidss_pkg.sv
// ----------------------------------------------------------------------------
// oidss_pkg
// Shared types, sizes and bit-search helpers for the ordered ID set.
// ----------------------------------------------------------------------------
package oidss_pkg;

  localparam int unsigned NUM_IDS   = 256;
  localparam int unsigned ID_W      = 8;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned BIT_AW    = $clog2(WORD_W);
  localparam int unsigned MAP_WORDS = NUM_IDS / WORD_W;
  localparam int unsigned WORD_AW   = $clog2(MAP_WORDS);

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [MAP_WORDS-1:0] summary_t;
  typedef logic [WORD_AW-1:0]   waddr_t;
  typedef logic [BIT_AW-1:0]    bidx_t;
  typedef logic [ID_W-1:0]      id_t;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_NEXT   = 2'd2,
    MODE_PREV   = 2'd3
  } mode_e;

  // map memory request from the engine
  typedef struct packed {
    logic   rd_en;
    waddr_t rd_addr;
    logic   wr_en;
    waddr_t wr_addr;
    word_t  wr_data;
  } map_req_t;

  typedef struct packed {
    logic found;
    id_t  id;
  } result_t;

  // bits strictly above position b
  function automatic word_t above_mask(input bidx_t b);
    above_mask = ({WORD_W{1'b1}} << b) << 1;
  endfunction

  // bits strictly below position b
  function automatic word_t below_mask(input bidx_t b);
    below_mask = ~({WORD_W{1'b1}} << b);
  endfunction

  function automatic bidx_t lowest_set(input word_t w);
    bidx_t idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) idx = bidx_t'(i);
    end
    lowest_set = idx;
  endfunction

  function automatic bidx_t highest_set(input word_t w);
    bidx_t idx;
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) idx = bidx_t'(i);
    end
    highest_set = idx;
  endfunction

endpackage

FILE: rtl/oidss_map_mem.sv
// ----------------------------------------------------------------------------
// oidss_map_mem
// Presence map: one 16-bit word per group of IDs, synchronous read with a
// registered output. Per-word valid bits make the whole map read as zero after
// reset without a clearing pass.
// ----------------------------------------------------------------------------
module oidss_map_mem
  import oidss_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  map_req_t req_i,
  output word_t    rdata_o
);

  word_t                mem_q [MAP_WORDS];
  logic [MAP_WORDS-1:0] valid_q;
  word_t                rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= valid_q[req_i.rd_addr] ? mem_q[req_i.rd_addr] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.wr_en) begin
      valid_q[req_i.wr_addr] <= 1'b1;
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/oidss_engine.sv
// ----------------------------------------------------------------------------
// oidss_engine
// Sequencer: reads the map word of the ID, then updates it or searches it;
// a search that misses its own word consults the summary and, if it marks
// a non-empty word in the search direction, reads that word.
// ----------------------------------------------------------------------------
module oidss_engine
  import oidss_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  mode_e    in_mode_i,
  input  id_t      in_id_i,
  output map_req_t map_req_o,
  input  word_t    map_rdata_i,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output result_t  res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e   state_q, state_d;
  mode_e    mode_q, mode_d;
  id_t      id_q, id_d;
  waddr_t   scan_q, scan_d;
  summary_t summary_q, summary_d;
  result_t  res_q, res_d;

  waddr_t   word_idx;
  bidx_t    bit_idx;
  word_t    cand;
  summary_t sum_cand;
  word_t    new_word;
  bidx_t    hit_bit;

  assign word_idx = id_q[ID_W-1:BIT_AW];
  assign bit_idx  = id_q[BIT_AW-1:0];

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    id_d      = id_q;
    scan_d    = scan_q;
    summary_d = summary_q;
    res_d     = res_q;
    map_req_o = '0;
    cand      = '0;
    sum_cand  = '0;
    new_word  = map_rdata_i;
    hit_bit   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d            = in_mode_i;
          id_d              = in_id_i;
          map_req_o.rd_en   = 1'b1;
          map_req_o.rd_addr = in_id_i[ID_W-1:BIT_AW];
          state_d           = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        res_d   = '0;
        state_d = ST_DONE;
        unique case (mode_q)
          MODE_INSERT, MODE_DELETE: begin
            if (mode_q == MODE_INSERT) begin
              new_word = map_rdata_i | (word_t'(1) << bit_idx);
            end else begin
              new_word = map_rdata_i & ~(word_t'(1) << bit_idx);
            end
            map_req_o.wr_en     = 1'b1;
            map_req_o.wr_addr   = word_idx;
            map_req_o.wr_data   = new_word;
            summary_d[word_idx] = |new_word;
          end
          MODE_NEXT, MODE_PREV: begin
            if (mode_q == MODE_NEXT) begin
              cand     = map_rdata_i & above_mask(bit_idx);
              sum_cand = summary_q & above_mask(word_idx);
              hit_bit  = lowest_set(cand);
              scan_d   = lowest_set(sum_cand);
            end else begin
              cand     = map_rdata_i & below_mask(bit_idx);
              sum_cand = summary_q & below_mask(word_idx);
              hit_bit  = highest_set(cand);
              scan_d   = highest_set(sum_cand);
            end
            if (|cand) begin
              res_d.found = 1'b1;
              res_d.id    = {word_idx, hit_bit};
            end else if (|sum_cand) begin
              map_req_o.rd_en   = 1'b1;
              map_req_o.rd_addr = scan_d;
              state_d           = ST_SCAN;
            end
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        // summary guarantees this word is non-empty
        hit_bit     = (mode_q == MODE_NEXT) ? lowest_set(map_rdata_i)
                                            : highest_set(map_rdata_i);
        res_d.found = 1'b1;
        res_d.id    = {scan_q, hit_bit};
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mode_q    <= MODE_INSERT;
      id_q      <= '0;
      scan_q    <= '0;
      summary_q <= '0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      id_q      <= id_d;
      scan_q    <= scan_d;
      summary_q <= summary_d;
      res_q     <= res_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

endmodule

FILE: rtl/ordered_id_set_successor.sv
// ----------------------------------------------------------------------------
// ordered_id_set_successor
// Ordered set of 8-bit slab IDs: insert, delete, find next greater and find
// previous smaller, one result per transaction.
//
//   channel   dir  tdata                 tuser
//   s_axis    in   slab_id[7:0]          mode[1:0]
//   m_axis    out  result_id[7:0]        found
//
// Updates and searches that hit in the ID's own map word read one map word;
// a search that moves to another word makes one more map memory read.
// One transaction is in the engine at a time; the output register lets the
// next transaction start while a result waits on m_axis.
// Reset empties the set at once (per-word valid bits plus summary register).
// ----------------------------------------------------------------------------
module ordered_id_set_successor
  import oidss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] slab_id
  input  logic [1:0] s_axis_tuser,   // [1:0] mode
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] result_id
  output logic       m_axis_tuser    // [0] found
);

  map_req_t map_req;
  word_t    map_rdata;
  logic     res_valid;
  logic     res_ready;
  result_t  res;

  logic     out_valid_q;
  result_t  out_res_q;

  oidss_map_mem u_map_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (map_req),
    .rdata_o (map_rdata)
  );

  oidss_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_mode_i   (mode_e'(s_axis_tuser)),
    .in_id_i     (s_axis_tdata),
    .map_req_o   (map_req),
    .map_rdata_i (map_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q.id;
  assign m_axis_tuser  = out_res_q.found;

`ifndef ASSERT_OFF
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transaction taken while one is in flight");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res.found |-> res.id == '0)
    else $error("result without a hit carries a nonzero ID");

  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready |=> m_axis_tvalid)
    else $error("engine result lost at the output register");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered ID set. A shadow bitmap of the members
// predicts every answer (update acks, next-greater and previous-smaller
// searches) and the answers are checked in order as they leave m_axis.
// Directed corner cases come first, then random traffic in dense, churn and
// sparse phases, with random stalls on both streams, one long output
// hold-off and one full drain.
// ----------------------------------------------------------------------------
module tb_top;
  import oidss_pkg::*;

  localparam int RANDOM_ITEMS = 1600;
  localparam int QUIET_ITEMS  = 200;     // tail of the run without idling
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 300000;

  class id_set_tracker;
    logic [NUM_IDS-1:0] members;
    result_t            pending_answers[$];
    int unsigned        mismatches;

    function new();
      members    = '0;
      mismatches = 0;
    endfunction

    task flag_mismatch(input string what);
      $display("%0t ns mismatch: %s", $time, what);
      mismatches++;
    endtask

    // apply the transaction to the shadow set and give the answer it must produce
    function result_t lookup_answer(input mode_e mode, input id_t id);
      result_t ans;
      int      k;
      ans = '0;
      case (mode)
        MODE_INSERT: members[id] = 1'b1;
        MODE_DELETE: members[id] = 1'b0;
        MODE_NEXT: begin
          for (k = int'(id) + 1; k < int'(NUM_IDS); k++) begin
            if (members[k]) begin
              ans.found = 1'b1;
              ans.id    = id_t'(k);
              break;
            end
          end
        end
        default: begin
          for (k = int'(id) - 1; k >= 0; k--) begin
            if (members[k]) begin
              ans.found = 1'b1;
              ans.id    = id_t'(k);
              break;
            end
          end
        end
      endcase
      return ans;
    endfunction

    function void note_request(input mode_e mode, input id_t id);
      pending_answers.push_back(lookup_answer(mode, id));
    endfunction

    task check_result(input logic found, input logic [ID_W-1:0] id);
      result_t want;
      if (pending_answers.size() == 0) begin
        flag_mismatch($sformatf("unexpected result found=%b id=%0d", found, id));
      end else begin
        want = pending_answers.pop_front();
        if (found !== want.found)
          flag_mismatch($sformatf("found got %b want %b", found, want.found));
        if (id !== want.id)
          flag_mismatch($sformatf("result_id got %0d want %0d", id, want.id));
      end
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] slab_id
  logic [1:0] s_axis_tuser;   // [1:0] mode
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] result_id
  logic       m_axis_tuser;   // [0] found

  id_set_tracker tracker = new();
  bit            idle_on = 1'b1;
  int            hold_request = 0;
  int unsigned   cycle_count = 0;

  ordered_id_set_successor uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // request side first: a result never leaves in the cycle its request enters
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        tracker.note_request(mode_e'(s_axis_tuser), s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        tracker.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  // output side: random back-pressure, plus a long hold-off on request
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_item(input mode_e mode, input id_t id);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= id;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  initial begin
    int    ins_pct;
    int    del_pct;
    int    pick;
    id_t   id;
    id_t   recent_id;
    mode_e mode;

    recent_id = '0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_INSERT;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // empty set, then both ends of the ID range and member zero
    send_item(MODE_NEXT, 8'd0);
    send_item(MODE_PREV, 8'd255);
    send_item(MODE_INSERT, 8'd0);
    send_item(MODE_INSERT, 8'd255);
    send_item(MODE_INSERT, 8'd0);        // already present
    send_item(MODE_NEXT, 8'd0);
    send_item(MODE_PREV, 8'd255);
    send_item(MODE_NEXT, 8'd255);
    send_item(MODE_PREV, 8'd0);
    send_item(MODE_DELETE, 8'd100);      // absent
    send_item(MODE_INSERT, 8'd17);
    send_item(MODE_NEXT, 8'd16);         // hit in the same word
    send_item(MODE_NEXT, 8'd17);         // query is a member, next is words away
    send_item(MODE_PREV, 8'd17);
    send_item(MODE_PREV, 8'd18);
    send_item(MODE_INSERT, 8'd170);
    send_item(MODE_NEXT, 8'd85);
    send_item(MODE_PREV, 8'd254);
    send_item(MODE_DELETE, 8'd0);
    send_item(MODE_PREV, 8'd17);
    send_item(MODE_DELETE, 8'd255);
    send_item(MODE_DELETE, 8'd17);
    send_item(MODE_DELETE, 8'd170);
    send_item(MODE_NEXT, 8'd0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n / 200) % 3)
        0:       begin ins_pct = 45; del_pct = 10; end   // fill up
        1:       begin ins_pct = 25; del_pct = 25; end   // churn
        default: begin ins_pct = 10; del_pct = 35; end   // thin out
      endcase
      if (n == RANDOM_ITEMS - QUIET_ITEMS)
        idle_on = 1'b0;
      if (n == 500)
        hold_request = HOLD_CYCLES;
      if (n == 900) begin
        s_axis_tvalid <= 1'b0;
        // let the monitor see the last accepted transaction before waiting for the queue
        @(posedge clk_i);
        while (tracker.pending_answers.size() != 0) @(posedge clk_i);
      end

      pick = $urandom_range(0, 3);
      if (pick < 2)
        id = id_t'($urandom_range(0, 255));
      else if (pick == 2)
        id = id_t'(recent_id + $urandom_range(0, 6) - 3);
      else if ($urandom_range(0, 1) == 0)
        id = id_t'($urandom_range(0, 15));
      else
        id = id_t'($urandom_range(240, 255));
      recent_id = id;

      pick = $urandom_range(0, 99);
      if (pick < ins_pct)
        mode = MODE_INSERT;
      else if (pick < ins_pct + del_pct)
        mode = MODE_DELETE;
      else if ($urandom_range(0, 1) == 0)
        mode = MODE_NEXT;
      else
        mode = MODE_PREV;
      send_item(mode, id);
    end

    s_axis_tvalid <= 1'b0;
    while (tracker.pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.pending_answers.size() != 0)
      tracker.flag_mismatch($sformatf("%0d results never arrived",
                                      tracker.pending_answers.size()));
    if (tracker.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
